// ===== hdl/rmea_pkg.sv =====
// Package for the rotation matrix to Euler angle pipeline.
// Holds the CORDIC arctangent table and result constants; no dependencies.
package rmea_pkg;

   localparam int AngTableLen = 24;
   localparam logic signed [33:0] HalfPiQ30 = 34'sd1686629713;
   localparam logic [15:0] PiQ13 = 16'd25736;

   // Return round(atan(2^-i) * 2^30)
   function automatic logic [29:0] atan_q30(input int i);
      logic [29:0] t;
      begin
         case (i)
            0: t = 30'd843314857;
            1: t = 30'd497837829;
            2: t = 30'd263043837;
            3: t = 30'd133525159;
            4: t = 30'd67021687;
            5: t = 30'd33543516;
            6: t = 30'd16775851;
            7: t = 30'd8388437;
            8: t = 30'd4194283;
            9: t = 30'd2097149;
            10: t = 30'd1048576;
            11: t = 30'd524288;
            12: t = 30'd262144;
            13: t = 30'd131072;
            14: t = 30'd65536;
            15: t = 30'd32768;
            16: t = 30'd16384;
            17: t = 30'd8192;
            18: t = 30'd4096;
            19: t = 30'd2048;
            20: t = 30'd1024;
            21: t = 30'd512;
            22: t = 30'd256;
            23: t = 30'd128;
            default: t = 30'd0;
         endcase
         return t;
      end
   endfunction

endpackage

// ===== hdl/rmea_isqrt.sv =====
// Pipelined integer square root of a 32-bit value, one result bit per stage.
// Depends on nothing; advances when enable is high.
module rmea_isqrt (
   input  logic        clock,
   input  logic        enable,
   input  logic [31:0] value,
   output logic [15:0] root
);

   logic [31:0] rem_ff [0:16];
   logic [15:0] root_ff [0:16];

   always_comb begin
      rem_ff[0]  = value;
      root_ff[0] = '0;
   end

   // Decide one root bit per stage from the top down
   genvar k;
   generate
      for (k = 0; k < 16; k++) begin : g_bit
         localparam int B = 15 - k;
         logic [31:0] trial;
         logic [31:0] rem_s_ff;
         logic [15:0] root_s_ff;
         always_comb begin
            trial = ({16'd0, root_ff[k]} << (B + 1)) + (32'd1 << (2 * B));
         end
         always_ff @(posedge clock) begin
            if (enable) begin
               if (rem_ff[k] >= trial) begin
                  rem_s_ff  <= rem_ff[k] - trial;
                  root_s_ff <= root_ff[k] | (16'd1 << B);
               end else begin
                  rem_s_ff  <= rem_ff[k];
                  root_s_ff <= root_ff[k];
               end
            end
         end
         assign rem_ff[k+1]  = rem_s_ff;
         assign root_ff[k+1] = root_s_ff;
      end
   endgenerate

   assign root = root_ff[16];

endmodule

// ===== hdl/rmea_cordic.sv =====
// Pipelined vectoring CORDIC giving atan2(y, x) as a saturated Q3.13 angle.
// Depends on rmea_pkg; one pipeline stage per iteration plus pre and round.
module rmea_cordic
   import rmea_pkg::*;
#(
   parameter int STEPS = 16
) (
   input  logic               clock,
   input  logic               enable,
   input  logic signed [17:0] y_in,
   input  logic signed [17:0] x_in,
   output logic signed [15:0] angle
);

   localparam int N = (STEPS < AngTableLen) ? STEPS : AngTableLen;
   localparam int W = 37;

   logic signed [W-1:0] x_ff [0:N];
   logic signed [W-1:0] y_ff [0:N];
   logic signed [33:0]  z_ff [0:N];
   logic                zero_ff [0:N];

   logic signed [W-1:0] xs, ys;
   logic signed [W-1:0] px_in, py_in;
   logic signed [33:0]  pz_in;
   logic signed [W-1:0] px_ff, py_ff;
   logic signed [33:0]  pz_ff;
   logic                pzero_ff;

   // Scale operands and fold the left half plane
   always_comb begin
      xs = W'(x_in) <<< 16;
      ys = W'(y_in) <<< 16;
      px_in = xs;
      py_in = ys;
      pz_in = '0;
      if (xs < 0) begin
         if (ys >= 0) begin
            px_in = ys;
            py_in = -xs;
            pz_in = HalfPiQ30;
         end else begin
            px_in = -ys;
            py_in = xs;
            pz_in = -HalfPiQ30;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         px_ff    <= px_in;
         py_ff    <= py_in;
         pz_ff    <= pz_in;
         pzero_ff <= (x_in == 18'sd0) && (y_in == 18'sd0);
      end
   end

   assign x_ff[0] = px_ff;
   assign y_ff[0] = py_ff;
   assign z_ff[0] = pz_ff;
   assign zero_ff[0] = pzero_ff;

   // One rotation per stage
   genvar i;
   generate
      for (i = 0; i < N; i++) begin : g_it
         logic signed [W-1:0] xr_ff, yr_ff;
         logic signed [33:0]  zr_ff;
         logic                zr0_ff;
         always_ff @(posedge clock) begin
            if (enable) begin
               zr0_ff <= zero_ff[i];
               if (y_ff[i] >= 0) begin
                  xr_ff <= x_ff[i] + (y_ff[i] >>> i);
                  yr_ff <= y_ff[i] - (x_ff[i] >>> i);
                  zr_ff <= z_ff[i] + 34'(atan_q30(i));
               end else begin
                  xr_ff <= x_ff[i] - (y_ff[i] >>> i);
                  yr_ff <= y_ff[i] + (x_ff[i] >>> i);
                  zr_ff <= z_ff[i] - 34'(atan_q30(i));
               end
            end
         end
         assign x_ff[i+1] = xr_ff;
         assign y_ff[i+1] = yr_ff;
         assign z_ff[i+1] = zr_ff;
         assign zero_ff[i+1] = zr0_ff;
      end
   endgenerate

   // Round half away from zero, saturate to pi
   logic [33:0] mag;
   logic [33:0] q;
   logic [15:0] qs;
   logic [15:0] ang_in, ang_ff;
   always_comb begin
      mag = z_ff[N][33] ? 34'(-z_ff[N]) : z_ff[N];
      q   = (mag + 34'd65536) >> 17;
      qs  = (q > 34'(PiQ13)) ? PiQ13 : q[15:0];
      if (zero_ff[N]) ang_in = '0;
      else ang_in = z_ff[N][33] ? 16'(-qs) : qs;
   end

   always_ff @(posedge clock) begin
      if (enable) ang_ff <= ang_in;
   end

   assign angle = ang_ff;

endmodule

// ===== hdl/rotation_matrix_to_euler_angles_top.sv =====
// ZYX Euler angles from a rotation matrix, fully pipelined.
// Registered steps in order: squares, then their sum, the square root, then the
// CORDIC pre-stage, iterations and rounding.
// Throughput: one request per cycle; a stall on the result side holds the
// whole pipeline, so nothing is dropped or repeated.
// Reset clears the valid bits and sets the singular threshold to 1.
// Depends on rmea_pkg, rmea_isqrt and rmea_cordic.
module rotation_matrix_to_euler_angles_top
   import rmea_pkg::*;
#(
   parameter int CORDIC_STEPS = 16,
   parameter int DATA_WIDTH   = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // r00, r10, r11, r12, r20, r21, r22 from bit 0 up, 16 bits each
   input  logic [111:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // angle_first, angle_middle, angle_third from bit 0 up
   output logic [47:0]  rsp_tdata,
   // singular
   output logic         rsp_tuser,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [10:0]  csr_data
);

   localparam int IW = (DATA_WIDTH < 16) ? DATA_WIDTH : 16;
   localparam int CN = (CORDIC_STEPS < AngTableLen) ? CORDIC_STEPS : AngTableLen;
   localparam int CLAT = CN + 2;
   localparam int LAT = 2 + 16 + CLAT;

   logic [10:0] thr_ff;
   logic        en;
   logic [LAT-1:0] vld_ff;

   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) thr_ff <= 11'd1;
      else if (csr_valid) thr_ff <= csr_data;
   end

   // Pipeline advances whenever the output slot is free or being drained
   assign en = !vld_ff[LAT-1] || rsp_tready;
   assign req_tready = en;

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else if (en) vld_ff <= {vld_ff[LAT-2:0], req_tvalid};
   end

   // Sign-extend inputs
   logic signed [15:0] r [0:6];
   genvar g;
   generate
      for (g = 0; g < 7; g++) begin : g_in
         assign r[g] = 16'(signed'(req_tdata[16*g +: IW]));
      end
   endgenerate

   // Stage 1: squares and operand capture
   logic [31:0] sq1_ff, sq2_ff, sum_ff;
   logic signed [15:0] s1_ff [0:6];
   always_ff @(posedge clock) begin
      if (en) begin
         sq1_ff <= 32'(r[5] * r[5]);
         sq2_ff <= 32'(r[6] * r[6]);
         for (int k = 0; k < 7; k++) s1_ff[k] <= r[k];
      end
   end
   logic signed [15:0] s2_ff [0:6];
   always_ff @(posedge clock) begin
      if (en) begin
         sum_ff <= sq1_ff + sq2_ff;
         for (int k = 0; k < 7; k++) s2_ff[k] <= s1_ff[k];
      end
   end

   logic [15:0] c_root;
   rmea_isqrt u_sqrt (.clock(clock), .enable(en), .value(sum_ff), .root(c_root));

   // Delay the matrix entries across the square root
   logic signed [15:0] dl_ff [0:15][0:6];
   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 7; k++) dl_ff[0][k] <= s2_ff[k];
         for (int s = 1; s < 16; s++) dl_ff[s] <= dl_ff[s-1];
      end
   end

   // Select CORDIC operands by the singular test
   logic sing;
   logic signed [17:0] y1, x1, y2, x2, y3, x3;
   always_comb begin
      sing = {5'd0, thr_ff} > c_root;
      y2 = -18'(dl_ff[15][4]);
      x2 = 18'({1'b0, c_root});
      if (sing) begin
         y1 = '0;
         x1 = '0;
         y3 = -18'(dl_ff[15][3]);
         x3 = 18'(dl_ff[15][2]);
      end else begin
         y1 = 18'(dl_ff[15][1]);
         x1 = 18'(dl_ff[15][0]);
         y3 = 18'(dl_ff[15][5]);
         x3 = 18'(dl_ff[15][6]);
      end
   end

   logic signed [15:0] a1, a2, a3;
   rmea_cordic #(.STEPS(CORDIC_STEPS)) u_c1
      (.clock(clock), .enable(en), .y_in(y1), .x_in(x1), .angle(a1));
   rmea_cordic #(.STEPS(CORDIC_STEPS)) u_c2
      (.clock(clock), .enable(en), .y_in(y2), .x_in(x2), .angle(a2));
   rmea_cordic #(.STEPS(CORDIC_STEPS)) u_c3
      (.clock(clock), .enable(en), .y_in(y3), .x_in(x3), .angle(a3));

   // Carry the singular flag alongside the CORDIC stages
   logic [CLAT-1:0] sg_ff;
   always_ff @(posedge clock) begin
      if (en) sg_ff <= {sg_ff[CLAT-2:0], sing};
   end

   assign rsp_tvalid = vld_ff[LAT-1];
   assign rsp_tdata  = {a3, a2, a1};
   assign rsp_tuser  = sg_ff[CLAT-1];

endmodule

// ===== hdl/rmea_checker.sv =====
// Port-level checker for the Euler angle pipeline, bound to the top level.
// Depends on the top-level port list only.
module rmea_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [47:0] rsp_tdata,
   input logic        rsp_tuser
);

   // Stalled output holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // Singular results report a zero first angle
   a_sing: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[15:0] == 16'd0)
      else $error("first angle nonzero when singular");

   // Ready follows the output slot
   a_rdy: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("request blocked with empty output");

   // No result right after reset
   a_rst: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind rotation_matrix_to_euler_angles_top rmea_checker u_checker (
   .clock(clock), .reset(reset), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
   .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
);
